// ----- rtl/multi_slot_timer_table_defines.svh -----
// ----------------------------------------------------------------------------
// multi_slot_timer_table_defines: assertion macros
// Shared concurrent-assertion shorthands for the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_TIMER_TABLE_DEFINES_SVH
`define MULTI_SLOT_TIMER_TABLE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MSTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define MSTT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/mstt_pkg.sv -----
// ----------------------------------------------------------------------------
// mstt_pkg: timer table package
// Sizes, command and result codes, sequencer states and record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package mstt_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int TIME_W   = 48;
  localparam int IVAL_W   = 32;
  localparam int PER_W    = 31;
  localparam int PEND_W   = 5;
  localparam int REC_W    = 1 + PER_W + TIME_W;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ARM       = 2'd0,
    KIND_CANCEL    = 2'd1,
    KIND_FIRE      = 2'd2,
    KIND_IDLE_TICK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HANDLE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              rep;
    logic [PER_W-1:0]  per;
    logic [TIME_W-1:0] dl;
  } rec_t;

  typedef struct packed {
    logic is_due;
    logic below_live;
    logic below_due;
  } cmp_t;

endpackage

`default_nettype wire

// ----- rtl/mstt_if.sv -----
// ----------------------------------------------------------------------------
// mstt_if: request and result channels
// Valid/ready channels carrying timer requests and timer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstt_in_if;
  import mstt_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [SLOT_W-1:0]   slot;
  logic signed [31:0]  interval_ms;
  logic                periodic;
  modport source (output valid, cmd, slot, interval_ms, periodic, input ready);
  modport sink   (input valid, cmd, slot, interval_ms, periodic, output ready);
endinterface

interface mstt_out_if;
  import mstt_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [SLOT_W-1:0]   fired_slot;
  logic                ok;
  logic                last;
  logic [PER_W-1:0]    next_delay_ms;
  logic [PEND_W-1:0]   pending;
  modport source (output valid, kind, fired_slot, ok, last, next_delay_ms, pending,
                  input ready);
  modport sink   (input valid, kind, fired_slot, ok, last, next_delay_ms, pending,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/mstt_ram.sv -----
// ----------------------------------------------------------------------------
// mstt_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/mstt_key_unit.sv -----
// ----------------------------------------------------------------------------
// mstt_key_unit: deadline order key and compares
// Offset key of one slot against now, due test and compares with best keys.
// ----------------------------------------------------------------------------
`default_nettype none

module mstt_key_unit (
  input  wire logic [mstt_pkg::TIME_W-1:0] deadline,
  input  wire logic [mstt_pkg::TIME_W-1:0] now,
  input  wire logic [mstt_pkg::TIME_W-1:0] best_live_key,
  input  wire logic [mstt_pkg::TIME_W-1:0] best_due_key,
  output logic      [mstt_pkg::TIME_W-1:0] key,
  output mstt_pkg::cmp_t                   cmp
);
  import mstt_pkg::*;

  logic [TIME_W-1:0] diff;

  // Key is the wrapped difference offset by half range: half means due now.
  always_comb begin
    diff           = deadline - now;
    key            = {~diff[TIME_W-1], diff[TIME_W-2:0]};
    cmp.is_due     = !key[TIME_W-1] || (key[TIME_W-2:0] == '0);
    cmp.below_live = key < best_live_key;
    cmp.below_due  = key < best_due_key;
  end

endmodule

`default_nettype wire

// ----- rtl/multi_slot_timer_table.sv -----
// An arm or cancel gives its result after one pass over the slot RAM.
// A tick marks the due set in a first pass; with no slot due it gives an idle tick
// result, else it handles the earliest due slot and gives its fire result after
// another pass; each further due slot is handled after the last result is taken.
// One request at a time: a new request is taken only while the table is idle.
// Reset: synchronous, active low; clears time, live and due bits, no sweep.
// ----------------------------------------------------------------------------
// multi_slot_timer_table: timer slot table
// Sequencer around a slot record RAM and one shared key/compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_timer_table (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mstt_in_if.sink    in_ch,
  mstt_out_if.source out_ch
);
  import mstt_pkg::*;

  // Sequencer and bookkeeping registers
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  kind_t               kind_r, kind_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                ok_r, ok_nxt;
  logic                last_r, last_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [SLOTS-1:0]    live_r, live_nxt;
  logic [SLOTS-1:0]    due_r, due_nxt;
  logic                mark_r, mark_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0]   rd_idx_r, rd_idx_nxt;
  // Best live key (for next delay) and best due key (next slot to fire)
  logic                bl_any_r, bl_any_nxt;
  logic [TIME_W-1:0]   bl_key_r, bl_key_nxt;
  logic                bd_any_r, bd_any_nxt;
  logic [TIME_W-1:0]   bd_key_r, bd_key_nxt;
  logic [SLOT_W-1:0]   bd_idx_r, bd_idx_nxt;
  logic                pick_rep_r, pick_rep_nxt;
  logic [PER_W-1:0]    pick_per_r, pick_per_nxt;

  // RAM port signals
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  rec_t                ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [REC_W-1:0]    ram_rdata;
  rec_t                rd_rec;

  logic [TIME_W-1:0]   ku_key;
  cmp_t                ku_cmp;

  logic                in_take;
  logic [PER_W-1:0]    ival_clamped;
  logic                lv;
  logic                cand;

  assign rd_rec = rec_t'(ram_rdata);

  mstt_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mstt_key_unit u_key (
    .deadline      (rd_rec.dl),
    .now           (now_r),
    .best_live_key (bl_key_r),
    .best_due_key  (bd_key_r),
    .key           (ku_key),
    .cmp           (ku_cmp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  // Clamp a negative interval to zero
  assign ival_clamped = in_ch.interval_ms[IVAL_W-1] ? '0 : in_ch.interval_ms[PER_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      live_r   <= '0;
      due_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      live_r   <= live_nxt;
      due_r    <= due_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    ok_r       <= ok_nxt;
    last_r     <= last_nxt;
    mark_r     <= mark_nxt;
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    bl_any_r   <= bl_any_nxt;
    bl_key_r   <= bl_key_nxt;
    bd_any_r   <= bd_any_nxt;
    bd_key_r   <= bd_key_nxt;
    bd_idx_r   <= bd_idx_nxt;
    pick_rep_r <= pick_rep_nxt;
    pick_per_r <= pick_per_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    kind_nxt     = kind_r;
    slot_nxt     = slot_r;
    ok_nxt       = ok_r;
    last_nxt     = last_r;
    now_nxt      = now_r;
    live_nxt     = live_r;
    due_nxt      = due_r;
    mark_nxt     = mark_r;
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    bl_any_nxt   = bl_any_r;
    bl_key_nxt   = bl_key_r;
    bd_any_nxt   = bd_any_r;
    bd_key_nxt   = bd_key_r;
    bd_idx_nxt   = bd_idx_r;
    pick_rep_nxt = pick_rep_r;
    pick_per_nxt = pick_per_r;
    ram_we       = 1'b0;
    ram_waddr    = bd_idx_r;
    ram_wdata    = '{rep: pick_rep_r, per: pick_per_r,
                     dl: now_r + {{(TIME_W-PER_W){1'b0}}, pick_per_r}};
    ram_raddr    = cnt_r[SLOT_W-1:0];
    lv           = live_r[rd_idx_r];
    cand         = mark_r ? (lv && ku_cmp.is_due) : due_r[rd_idx_r];

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd_nxt    = cmd_t'(in_ch.cmd);
          slot_nxt   = in_ch.slot;
          mark_nxt   = 1'b0;
          last_nxt   = 1'b1;
          cnt_nxt    = '0;
          bl_any_nxt = 1'b0;
          bd_any_nxt = 1'b0;
          case (cmd_t'(in_ch.cmd))
            CMD_ARM: begin
              // Load the record and mark the slot live; re-arm restarts it
              ram_we    = 1'b1;
              ram_waddr = in_ch.slot;
              ram_wdata = '{rep: in_ch.periodic, per: ival_clamped,
                            dl: now_r + {{(TIME_W-PER_W){1'b0}}, ival_clamped}};
              live_nxt[in_ch.slot] = 1'b1;
              ok_nxt    = 1'b1;
              kind_nxt  = KIND_ARM;
              state_nxt = ST_SCAN;
            end
            CMD_CANCEL: begin
              ok_nxt    = live_r[in_ch.slot];
              live_nxt[in_ch.slot] = 1'b0;
              kind_nxt  = KIND_CANCEL;
              state_nxt = ST_SCAN;
            end
            CMD_TICK: begin
              // Advance time, then mark the due set in the first pass
              now_nxt   = now_r + TIME_W'(1);
              due_nxt   = '0;
              mark_nxt  = 1'b1;
              ok_nxt    = 1'b0;
              state_nxt = ST_SCAN;
            end
            default: begin
              // Unknown command: drop it
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one RAM read per cycle, evaluate the previous read
        if (cnt_r < CNT_W'(SLOTS)) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[SLOT_W-1:0];
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (mark_r) begin
            due_nxt[rd_idx_r] = cand;
          end
          if (lv && (!bl_any_r || ku_cmp.below_live)) begin
            bl_any_nxt = 1'b1;
            bl_key_nxt = ku_key;
          end
          if (cand && (!bd_any_r || ku_cmp.below_due)) begin
            bd_any_nxt   = 1'b1;
            bd_key_nxt   = ku_key;
            bd_idx_nxt   = rd_idx_r;
            pick_rep_nxt = rd_rec.rep;
            pick_per_nxt = rd_rec.per;
          end
        end else if (cnt_r == CNT_W'(SLOTS)) begin
          if (mark_r && bd_any_r) begin
            state_nxt = ST_HANDLE;
          end else begin
            state_nxt = ST_OUT;
            if (cmd_r == CMD_TICK) begin
              if (mark_r) begin
                kind_nxt = KIND_IDLE_TICK;
                slot_nxt = '0;
                last_nxt = 1'b1;
              end else begin
                kind_nxt = KIND_FIRE;
                last_nxt = (due_r == '0);
              end
            end
          end
        end
      end

      ST_HANDLE: begin
        // Fire the picked slot: re-arm from now or free it
        if (pick_rep_r) begin
          ram_we = 1'b1;
        end else begin
          live_nxt[bd_idx_r] = 1'b0;
        end
        due_nxt[bd_idx_r] = 1'b0;
        slot_nxt   = bd_idx_r;
        mark_nxt   = 1'b0;
        cnt_nxt    = '0;
        bl_any_nxt = 1'b0;
        bd_any_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end

      ST_OUT: begin
        // Hold the result until taken, then advance to the next due slot of a tick or go idle
        if (out_ch.ready) begin
          if (cmd_r == CMD_TICK && due_r != '0) begin
            state_nxt = ST_HANDLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result payload
  assign out_ch.valid      = (state_r == ST_OUT);
  assign out_ch.kind       = kind_r;
  assign out_ch.fired_slot = slot_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.last       = last_r;
  assign out_ch.pending    = PEND_W'($countones(live_r));
  assign out_ch.next_delay_ms =
    (!bl_any_r || !bl_key_r[TIME_W-1] || (bl_key_r[TIME_W-2:0] == '0)) ?
    '0 : bl_key_r[PER_W-1:0];

  `include "multi_slot_timer_table_defines.svh"

  `MSTT_NEVER(a_due_not_live, (due_r & ~live_r) != '0, "due slot is not live")
  `MSTT_NEVER(a_ready_while_result, in_ch.ready && out_ch.valid, "ready with result held")
  `MSTT_ASSERT(a_fire_ok_low,
               (out_ch.valid && out_ch.kind == KIND_FIRE) |-> !out_ch.ok,
               "fire with ok")
  `MSTT_ASSERT(a_tick_advance,
               (in_take && in_ch.cmd == CMD_TICK) |=> (now_r == $past(now_r) + TIME_W'(1)),
               "time did not advance")
  `MSTT_ASSERT(a_handle_has_pick,
               (state_r == ST_HANDLE) |-> (due_r[bd_idx_r] && live_r[bd_idx_r]),
               "handle without due pick")

endmodule

`default_nettype wire

// ----- dv/mstt_checker.sv -----
// ----------------------------------------------------------------------------
// mstt_checker: timer table scoreboard
// Tracks the slot table from accepted requests, builds the expected results
// and compares every accepted result with the oldest one still expected.
// ----------------------------------------------------------------------------
`default_nettype none

module mstt_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  mstt_in_if        in_ch,
  mstt_out_if       out_ch,
  output int        fail_count,
  output int        awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import mstt_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic              last;
    logic [PER_W-1:0]  delay;
    logic [PEND_W-1:0] pend;
  } timer_result_t;

  localparam logic [TIME_W-1:0] HALF = 48'h8000_0000_0000;

  logic [TIME_W-1:0] now_t;
  logic              armed  [SLOTS];
  logic              repeat_q [SLOTS];
  logic [PER_W-1:0]  period_q [SLOTS];
  logic [TIME_W-1:0] due_at [SLOTS];
  timer_result_t     result_q [$];

  // Offset of a deadline from now; HALF means due exactly now.
  function automatic logic [TIME_W-1:0] lag_key(int s);
    return due_at[s] - now_t + HALF;
  endfunction

  function automatic void push_result(kind_t kind, logic [SLOT_W-1:0] slot, logic ok,
                                      logic last);
    timer_result_t r;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] k;
    bit any;
    int n;
    any = 0;
    best = '0;
    n = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (armed[s]) begin
        n++;
        k = lag_key(s);
        if (!any || k < best) begin
          best = k;
          any = 1;
        end
      end
    end
    r.kind = kind;
    r.slot = slot;
    r.ok = ok;
    r.last = last;
    r.delay = (!any || best <= HALF) ? '0 : PER_W'(best - HALF);
    r.pend = PEND_W'(n);
    result_q = {result_q, r};
  endfunction

  function automatic void apply_request(logic [1:0] cmd, logic [SLOT_W-1:0] slot,
                                        logic signed [31:0] iv, logic per);
    logic due [SLOTS];
    int ndue;
    int pick;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] k;
    case (cmd)
      CMD_ARM: begin
        if (iv < 0) iv = 0;
        period_q[slot] = PER_W'(iv);
        repeat_q[slot] = per;
        due_at[slot] = now_t + TIME_W'(iv[PER_W-1:0]);
        armed[slot] = 1'b1;
        push_result(KIND_ARM, slot, 1'b1, 1'b1);
      end
      CMD_CANCEL: begin
        k[0] = armed[slot];
        armed[slot] = 1'b0;
        push_result(KIND_CANCEL, slot, k[0], 1'b1);
      end
      CMD_TICK: begin
        now_t = now_t + 1;
        ndue = 0;
        // Freeze the firing set before any slot is handled.
        for (int s = 0; s < SLOTS; s++) begin
          due[s] = armed[s] && lag_key(s) <= HALF;
          if (due[s]) ndue++;
        end
        if (ndue == 0) push_result(KIND_IDLE_TICK, '0, 1'b0, 1'b1);
        for (int i = 0; i < ndue; i++) begin
          pick = -1;
          best = '0;
          for (int s = 0; s < SLOTS; s++) begin
            if (due[s]) begin
              k = lag_key(s);
              if (pick < 0 || k < best) begin
                best = k;
                pick = s;
              end
            end
          end
          due[pick] = 1'b0;
          if (repeat_q[pick]) due_at[pick] = now_t + TIME_W'(period_q[pick]);
          else armed[pick] = 1'b0;
          push_result(KIND_FIRE, SLOT_W'(pick), 1'b0, i == ndue - 1);
        end
      end
      default: ;  // unknown command: no change, no result
    endcase
  endfunction

  always @(posedge clk) begin
    timer_result_t e;
    if (!rst_n) begin
      now_t = '0;
      for (int s = 0; s < SLOTS; s++) begin
        armed[s] = 1'b0;
        repeat_q[s] = 1'b0;
        period_q[s] = '0;
        due_at[s] = '0;
      end
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        apply_request(in_ch.cmd, in_ch.slot, in_ch.interval_ms, in_ch.periodic);
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result kind=%0d slot=%0d", out_ch.kind, out_ch.fired_slot);
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (out_ch.kind != e.kind ||
              out_ch.fired_slot != e.slot || out_ch.ok != e.ok ||
              out_ch.last != e.last || out_ch.next_delay_ms != e.delay ||
              out_ch.pending != e.pend)
            fail_count <= fail_count + 1;
          if (out_ch.kind != e.kind)
            $error("kind: expected %0d actual %0d", e.kind, out_ch.kind);
          if (out_ch.fired_slot != e.slot)
            $error("fired_slot: expected %0d actual %0d", e.slot, out_ch.fired_slot);
          if (out_ch.ok != e.ok)
            $error("ok: expected %0d actual %0d", e.ok, out_ch.ok);
          if (out_ch.last != e.last)
            $error("last: expected %0d actual %0d", e.last, out_ch.last);
          if (out_ch.next_delay_ms != e.delay)
            $error("next_delay_ms: expected %0d actual %0d", e.delay, out_ch.next_delay_ms);
          if (out_ch.pending != e.pend)
            $error("pending: expected %0d actual %0d", e.pend, out_ch.pending);
        end
      end
    end
    awaiting <= result_q.size();
  end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: timer table top
// Drives directed and random timer requests with random gaps and output
// stalls, and reports the scoreboard verdict at the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mstt_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // cycles without any handshake
  localparam int HOLD_CYCLES = 600;   // long receiver hold-off

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   awaiting;
  int   quiet_cycles = 0;
  bit   calm = 0;       // no idling on either side while set
  bit   hold_req = 0;   // ask the receiver for a long hold-off

  mstt_in_if  in_ch ();
  mstt_out_if out_ch ();

  multi_slot_timer_table dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  mstt_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .awaiting(awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= 36;
        @(posedge clk);
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one request and hold it until it is taken; idle at random after.
  task automatic send_request(cmd_t cmd, int slot, logic signed [31:0] iv, bit per);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.slot <= SLOT_W'(slot);
    in_ch.interval_ms <= iv;
    in_ch.periodic <= per;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    if (!calm && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 36) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Mostly short intervals so slots fire; some negative, wide and long ones.
  function automatic logic signed [31:0] pick_interval();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(12);
    if (r < 75) return $urandom | 32'h8000_0000;
    if (r < 85) return $urandom;
    return $urandom_range(300, 13);
  endfunction

  initial begin
    int r;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_TICK;
    in_ch.slot <= '0;
    in_ch.interval_ms <= '0;
    in_ch.periodic <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero period, ties, extremes, cancels, unknown command.
    send_request(CMD_ARM, 0, 0, 1);
    send_request(CMD_TICK, 0, 0, 0);
    send_request(CMD_TICK, 0, 0, 0);
    send_request(CMD_ARM, 15, 32'sh7fff_ffff, 0);
    send_request(CMD_ARM, 7, 32'sh8000_0000, 0);
    send_request(CMD_ARM, 3, -1, 1);
    send_request(CMD_ARM, 4, 2, 0);
    send_request(CMD_ARM, 2, 2, 1);
    send_request(CMD_ARM, 9, 1, 0);
    send_request(CMD_TICK, 0, 0, 0);
    send_request(CMD_TICK, 0, 0, 0);
    send_request(CMD_ARM, 4, 5, 1);
    send_request(CMD_ARM, 4, 1, 0);
    send_request(CMD_CANCEL, 15, 0, 0);
    send_request(CMD_CANCEL, 15, 0, 0);
    send_request(CMD_CANCEL, 0, 0, 0);
    send_request(CMD_NONE, 5, 32'sh5555_aaaa, 1);
    send_request(CMD_TICK, 0, 0, 0);
    for (int s = 0; s < SLOTS; s++) send_request(CMD_ARM, s, 0, s[0]);
    send_request(CMD_TICK, 0, 0, 0);
    send_request(CMD_TICK, 0, 0, 0);

    for (int i = 0; i < 144; i++) begin
      // Fill the block while the receiver holds off.
      if (i == 40) hold_req = 1;
      // Pause the sender until every result is back.
      if (i == 90) drain_results();
      calm = (i >= 105 && i < 135);
      r = $urandom_range(99);
      if (r < 45) send_request(CMD_TICK, $urandom_range(15), $urandom,
                               1'($urandom_range(1)));
      else if (r < 80) send_request(CMD_ARM, $urandom_range(15), pick_interval(),
                                    1'($urandom_range(1)));
      else if (r < 96) send_request(CMD_CANCEL, $urandom_range(15), $urandom,
                                    1'($urandom_range(1)));
      else send_request(CMD_NONE, $urandom_range(15), $urandom, 1'($urandom_range(1)));
    end
    calm = 0;

    drain_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/mstt_pkg.sv
rtl/mstt_if.sv
rtl/mstt_ram.sv
rtl/mstt_key_unit.sv
rtl/multi_slot_timer_table.sv
dv/mstt_checker.sv
dv/testbench.sv
